[sv/bmsp_pkg.sv]
// Package: shared constants, register indexes and word types of the bus master poller.
`default_nettype none
package bmsp_pkg;

  // Number of slave addresses scanned at boot (1..SLAVE_COUNT)
  localparam int SLAVE_COUNT = 16;
  localparam int IDX_W       = (SLAVE_COUNT > 1) ? $clog2(SLAVE_COUNT) : 1;
  localparam int MAP_W       = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT_TICKS     = 2'd0,
    CFG_POLL_PERIOD_TICKS = 2'd1,
    CFG_ACK_FUNCTION_CODE = 2'd2
  } cfg_idx_t;

  // Input request types
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_SEND  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  // Reset values of the configuration registers
  localparam logic [7:0]  TIMEOUT_RESET     = 8'd10;
  localparam logic [7:0]  POLL_PERIOD_RESET = 8'd100;
  localparam logic [15:0] ACK_FUNC_RESET    = 16'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_address;
    logic [15:0] rx_function;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_address;
    logic [15:0] tx_function;
    logic        waiting;
    logic        timed_out;
    logic        boot_done;
    logic [15:0] active_map;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_word_t;

  // Live configuration handed from the register file to the core
  typedef struct packed {
    logic [7:0]  timeout_ticks;
    logic [7:0]  poll_period_ticks;
    logic [15:0] ack_function_code;
  } cfg_regs_t;

endpackage
`default_nettype wire

[sv/bmsp_ifs.sv]
// Interfaces: valid/ready channels for requests, results and configuration writes.
`default_nettype none
interface bmsp_in_if import bmsp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmsp_out_if import bmsp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmsp_cfg_if import bmsp_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/bmsp_cfg_regs.sv]
// Configuration register file: timeout, poll period and acknowledge function code.
`default_nettype none
module bmsp_cfg_regs import bmsp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  bmsp_cfg_if.sink    cfg,
  output cfg_regs_t   regs
);

  logic [7:0]  timeout_ticks;
  logic [7:0]  poll_period_ticks;
  logic [15:0] ack_function_code;

  // Writes are always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks     <= TIMEOUT_RESET;
      poll_period_ticks <= POLL_PERIOD_RESET;
      ack_function_code <= ACK_FUNC_RESET;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.data.index))
        CFG_TIMEOUT_TICKS:     timeout_ticks     <= cfg.data.data[7:0];
        CFG_POLL_PERIOD_TICKS: poll_period_ticks <= cfg.data.data[7:0];
        CFG_ACK_FUNCTION_CODE: ack_function_code <= cfg.data.data;
        default: ;
      endcase
    end
  end

  assign regs.timeout_ticks     = timeout_ticks;
  assign regs.poll_period_ticks = poll_period_ticks;
  assign regs.ack_function_code = ack_function_code;

endmodule
`default_nettype wire

[sv/bmsp_core.sv]
// Poller core: per-word state update (timers, boot scan, poll rounds, active map).
`default_nettype none
module bmsp_core import bmsp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_word_t  word,
  input  wire cfg_regs_t regs,
  output out_word_t      result
);

  logic                   normal_mode, normal_mode_next;
  logic [6:0]             boot_index, boot_index_next;
  logic [6:0]             poll_index, poll_index_next;
  logic                   poll_pending, poll_pending_next;
  logic                   wait_flag, wait_flag_next;
  logic                   timeout_flag, timeout_flag_next;
  logic [7:0]             wait_address, wait_address_next;
  logic [15:0]            wait_function, wait_function_next;
  logic [7:0]             reply_timer, reply_timer_next;
  logic [7:0]             period_counter, period_counter_next;
  logic [SLAVE_COUNT-1:0] slave_active, slave_active_next;

  logic        start;
  logic [7:0]  start_addr;
  logic [7:0]  rx_idx;
  logic        rx_in_range;

  // Received address to slave bit index
  assign rx_idx      = word.rx_address - 8'd1;
  assign rx_in_range = (word.rx_address >= 8'd1) &&
                       ({24'd0, word.rx_address} <= 32'(SLAVE_COUNT));

  // Next state for one accepted word
  always_comb begin
    normal_mode_next    = normal_mode;
    boot_index_next     = boot_index;
    poll_index_next     = poll_index;
    poll_pending_next   = poll_pending;
    wait_flag_next      = wait_flag;
    timeout_flag_next   = timeout_flag;
    wait_address_next   = wait_address;
    wait_function_next  = wait_function;
    reply_timer_next    = reply_timer;
    period_counter_next = period_counter;
    slave_active_next   = slave_active;
    start               = 1'b0;
    start_addr          = 8'd0;

    case (req_kind_t'(word.req_type))
      REQ_TICK: begin
        if (wait_flag) begin
          reply_timer_next = reply_timer + 8'd1;
          if (reply_timer_next > regs.timeout_ticks) begin
            timeout_flag_next = 1'b1;
            wait_flag_next    = 1'b0;
            reply_timer_next  = 8'd0;
          end
        end
        if (period_counter >= regs.poll_period_ticks) begin
          poll_pending_next   = 1'b1;
          period_counter_next = 8'd1;
        end else begin
          period_counter_next = period_counter + 8'd1;
        end
      end
      REQ_FRAME: begin
        if (wait_flag) begin
          if (word.rx_address == wait_address && word.rx_function == wait_function &&
              word.rx_function == regs.ack_function_code && rx_in_range) begin
            slave_active_next[rx_idx[IDX_W-1:0]] = 1'b1;
          end
          wait_flag_next    = 1'b0;
          timeout_flag_next = 1'b0;
        end
      end
      REQ_SEND: begin
        // Boot scan: one acknowledge request per address
        if (!normal_mode) begin
          if ({25'd0, boot_index} >= 32'(SLAVE_COUNT)) begin
            normal_mode_next = 1'b1;
          end else if (!wait_flag) begin
            start           = 1'b1;
            start_addr      = {1'b0, boot_index} + 8'd1;
            boot_index_next = boot_index + 7'd1;
          end
        end
        // Poll round over active slaves
        if (normal_mode_next && poll_pending) begin
          if ({25'd0, poll_index} >= 32'(SLAVE_COUNT)) begin
            poll_index_next   = 7'd0;
            poll_pending_next = 1'b0;
          end else if (!wait_flag) begin
            if (slave_active[poll_index[IDX_W-1:0]]) begin
              start      = 1'b1;
              start_addr = {1'b0, poll_index} + 8'd1;
            end
            poll_index_next = poll_index + 7'd1;
          end
        end
        if (start) begin
          wait_flag_next     = 1'b1;
          timeout_flag_next  = 1'b0;
          wait_address_next  = start_addr;
          wait_function_next = regs.ack_function_code;
          reply_timer_next   = 8'd0;
        end
      end
      default: ;
    endcase
  end

  // Result word: send info plus state after the word
  always_comb begin
    result.tx_valid    = start;
    result.tx_address  = start ? start_addr : 8'd0;
    result.tx_function = start ? regs.ack_function_code : 16'd0;
    result.waiting     = wait_flag_next;
    result.timed_out   = timeout_flag_next;
    result.boot_done   = normal_mode_next;
    for (int i = 0; i < MAP_W; i++) begin
      result.active_map[i] = (i < SLAVE_COUNT) ? slave_active_next[i % SLAVE_COUNT] : 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_mode    <= 1'b0;
      boot_index     <= 7'd0;
      poll_index     <= 7'd0;
      poll_pending   <= 1'b0;
      wait_flag      <= 1'b0;
      timeout_flag   <= 1'b0;
      wait_address   <= 8'd0;
      wait_function  <= 16'd0;
      reply_timer    <= 8'd0;
      period_counter <= 8'd0;
      slave_active   <= '0;
    end else if (step) begin
      normal_mode    <= normal_mode_next;
      boot_index     <= boot_index_next;
      poll_index     <= poll_index_next;
      poll_pending   <= poll_pending_next;
      wait_flag      <= wait_flag_next;
      timeout_flag   <= timeout_flag_next;
      wait_address   <= wait_address_next;
      wait_function  <= wait_function_next;
      reply_timer    <= reply_timer_next;
      period_counter <= period_counter_next;
      slave_active   <= slave_active_next;
    end
  end

  // Normal mode is never left once entered
  a_mode_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(normal_mode) && !$past(rst) |-> normal_mode)
    else $error("normal mode dropped");

  // A slave once marked active stays active
  a_active_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((slave_active & $past(slave_active)) == $past(slave_active)))
    else $error("active slave cleared");

  // A sent request always opens a fresh wait
  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    step && start |=> wait_flag && !timeout_flag && reply_timer == 8'd0)
    else $error("send without wait");

  // Boot scan only advances while in boot mode
  a_boot_index: assert property (@(posedge clk) disable iff (rst)
    normal_mode |=> $stable(boot_index))
    else $error("boot index moved in normal mode");

endmodule
`default_nettype wire

[sv/bmsp_out_reg.sv]
// Output register: holds one result word until the receiver takes it.
`default_nettype none
module bmsp_out_reg import bmsp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_word_t result,
  output logic           can_load,
  bmsp_out_if.source     rsp
);

  logic      valid;
  out_word_t data;

  // Room when empty or when the held word leaves this cycle
  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= result;
    end
  end

  assign rsp.valid = valid;
  assign rsp.data  = data;

endmodule
`default_nettype wire

[sv/bus_master_slave_poller.sv]
// Top level: bus master that scans for slaves at boot and then polls the active ones.
//
// Channels:
//   req - request words: 10 ms tick, received frame (address, function) or send step.
//   rsp - one result word per request word: request sent (address, function),
//         waiting / timed_out / boot_done flags and the map of active slaves.
//   cfg - register writes: 0 timeout ticks, 1 poll period ticks, 2 ack function code.
// Timing: a request word's result word is formed combinationally and captured in
// the output register, which raises rsp.valid. Throughput: one word per cycle
// unless rsp.ready stalls, since the whole state update is one pass of logic
// between the state registers and the output register.
// Reset (rst, synchronous): all state cleared, boot mode, no slave active,
// registers back to 10 / 100 / 1. No clearing pass; words are taken right away.
// Stall: while a result waits and rsp.ready is low, req.ready is low; a result
// leaving in the same cycle lets the next request in. Config writes are always
// taken and must be issued only while no result is outstanding.
`default_nettype none
module bus_master_slave_poller import bmsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bmsp_in_if.sink    req,
  bmsp_out_if.source rsp,
  bmsp_cfg_if.sink   cfg
);

  cfg_regs_t regs;
  out_word_t result;
  logic      can_load;
  logic      step;

  assign req.ready = can_load;
  assign step      = req.valid && can_load;

  bmsp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bmsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .word   (req.data),
    .regs   (regs),
    .result (result)
  );

  bmsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire
